[rtl/core/bapid_pkg.sv]
// Shared types and constants for the ball axis PID controller.
// Used by the top level and the shared multiplier.
`default_nettype none

package bapid_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int DIFF_W  = 17;   // meas - target, never wrapped
    localparam int PF_W    = 11;   // path factor, 0..1024
    localparam int EPOS_W  = 13;   // softened position error
    localparam int ESPD_W  = 18;   // softened speed error
    localparam int INTEG_W = 32;
    localparam int SUM_W   = 28;
    localparam int ANGLE_W = 9;
    localparam int ACC_W   = 18;   // filter accumulator, Q4 plus 8 fraction bits
    localparam int TICK_W  = 14;
    localparam int ALPHA_W = 9;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Path factor divide: 2457600 / (2400 + |d|). The quotient fits 11 bits,
    // so the top bits of the numerator seed the remainder.
    localparam logic [21:0] PF_NUM    = 22'd2457600;
    localparam logic [10:0] PF_NUM_LO = PF_NUM[10:0];
    localparam logic [16:0] PF_SEED   = 17'(PF_NUM >> PF_W);
    localparam logic [16:0] PF_BASE   = 17'd2400;

    localparam logic signed [SUM_W-1:0] ANGLE_MAX = SUM_W'(240);
    localparam logic signed [SUM_W-1:0] ANGLE_MIN = -SUM_W'(240);
    localparam logic [ALPHA_W-1:0]      ALPHA_ONE = ALPHA_W'(256);

    // Register reset values
    localparam logic [15:0] RST_PROP  = 16'd1638;
    localparam logic [15:0] RST_INTEG = 16'd98;
    localparam logic [15:0] RST_DERIV = 16'd581;
    localparam logic [TICK_W-1:0]  RST_TICK  = TICK_W'(164);
    localparam logic [ALPHA_W-1:0] RST_ALPHA = ALPHA_W'(64);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_WEIGHT  = 3'd0,
        CFG_INTEG_WEIGHT = 3'd1,
        CFG_DERIV_WEIGHT = 3'd2,
        CFG_TICK_PERIOD  = 3'd3,
        CFG_FILTER_ALPHA = 3'd4,
        CFG_TARGET_POS   = 3'd5,
        CFG_TARGET_SPEED = 3'd6
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL_EPOS,
        S_MUL_ESPD,
        S_MUL_INTEG,
        S_MUL_PROP,
        S_MUL_ITERM,
        S_MUL_DERIV,
        S_CLAMP,
        S_MUL_FILT,
        S_DONE
    } t_state;

    // Request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

`default_nettype wire

[rtl/core/bapid_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on bapid_pkg for operand widths and the request struct.
`default_nettype none

module bapid_mul (
    input  wire logic                  i_clk,
    input  wire bapid_pkg::t_mul_req   i_req,
    output logic [bapid_pkg::MUL_P_W-1:0] o_prod
);

    logic signed [bapid_pkg::MUL_P_W-1:0] r_prod;

    // Product loads only when a step issues a request, so it holds under stall
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed(i_req.a) * $signed(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/core/ball_axis_pid_controller.sv]
// Top level of the single-axis ball PID controller: sequencer, state and config.
// Depends on bapid_pkg and the shared multiplier bapid_mul.
`default_nettype none

// One input word (position and speed) yields one tilt word. A word is taken in
// the idle state and passes through a setup step, an 11-bit restoring divide
// for the path factor (one quotient bit per cycle), and nine steps for the
// error terms, the integral, the PID sum, the clamp and the low-pass filter,
// whose multiplies share a single registered 24x19 multiplier. The result sits
// in an output register, and a new word can be taken once it is stored there.
// Input ready is held low while a word is being worked on; if the previous
// result has not been taken, the last step waits for it, and input ready
// stays low for that long. Config writes are always taken and should be
// issued only while the block is idle.
module ball_axis_pid_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [15:0] meas_pos, [31:16] meas_speed
    input  wire logic        i_s_axis_tuser,  // [0] restart
    // result words
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,  // [8:0] tilt_angle, [15:9] zero
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [bapid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers
    logic signed [15:0] r_prop_w, r_integ_w, r_deriv_w, r_tgt_pos, r_tgt_spd;
    logic [bapid_pkg::TICK_W-1:0]  r_tick;
    logic [bapid_pkg::ALPHA_W-1:0] r_alpha;

    // Sequencer and datapath registers
    bapid_pkg::t_state r_state, n_state;
    logic signed [bapid_pkg::DIFF_W-1:0]  r_d, n_d, r_ds, n_ds;
    logic [16:0]                          r_div, n_div, r_rem, n_rem;
    logic [bapid_pkg::PF_W-1:0]           r_pf, n_pf;
    logic [3:0]                           r_cnt, n_cnt;
    logic signed [bapid_pkg::EPOS_W-1:0]  r_epos, n_epos;
    logic signed [bapid_pkg::ESPD_W-1:0]  r_espd, n_espd;
    logic signed [bapid_pkg::INTEG_W-1:0] r_ei, n_ei;
    logic signed [bapid_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic signed [bapid_pkg::ANGLE_W-1:0] r_x, n_x;
    logic signed [bapid_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic                                 r_out_valid, n_out_valid;
    logic signed [bapid_pkg::ANGLE_W-1:0] r_tilt, n_tilt;

    bapid_pkg::t_mul_req            mul_req;
    logic [bapid_pkg::MUL_P_W-1:0]  prod;

    bapid_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    logic in_acc;
    assign o_s_axis_tready = (r_state == bapid_pkg::S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_tilt};

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_w  <= bapid_pkg::RST_PROP;
            r_integ_w <= bapid_pkg::RST_INTEG;
            r_deriv_w <= bapid_pkg::RST_DERIV;
            r_tick    <= bapid_pkg::RST_TICK;
            r_alpha   <= bapid_pkg::RST_ALPHA;
            r_tgt_pos <= '0;
            r_tgt_spd <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bapid_pkg::t_cfg_idx'(i_cfg_index))
                bapid_pkg::CFG_PROP_WEIGHT:  r_prop_w  <= i_cfg_data;
                bapid_pkg::CFG_INTEG_WEIGHT: r_integ_w <= i_cfg_data;
                bapid_pkg::CFG_DERIV_WEIGHT: r_deriv_w <= i_cfg_data;
                bapid_pkg::CFG_TICK_PERIOD:  r_tick    <= i_cfg_data[bapid_pkg::TICK_W-1:0];
                bapid_pkg::CFG_FILTER_ALPHA: r_alpha   <= i_cfg_data[bapid_pkg::ALPHA_W-1:0];
                bapid_pkg::CFG_TARGET_POS:   r_tgt_pos <= i_cfg_data;
                bapid_pkg::CFG_TARGET_SPEED: r_tgt_spd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bapid_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ei        <= '0;
            r_acc       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ei        <= n_ei;
            r_acc       <= n_acc;
        end
        r_d    <= n_d;
        r_ds   <= n_ds;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_pf   <= n_pf;
        r_cnt  <= n_cnt;
        r_epos <= n_epos;
        r_espd <= n_espd;
        r_sum  <= n_sum;
        r_x    <= n_x;
        r_tilt <= n_tilt;
    end

    // Next state, datapath updates and multiplier requests
    always_comb begin
        logic [16:0]                          mag;
        logic [17:0]                          rem2;
        logic                                 ge;
        logic signed [bapid_pkg::INTEG_W:0]   integ_sum;
        logic signed [bapid_pkg::SUM_W-1:0]   sum_full;
        logic signed [bapid_pkg::ACC_W:0]     fdiff;
        logic signed [19:0]                   delta;
        logic signed [19:0]                   acc_sum;
        logic [bapid_pkg::ALPHA_W-1:0]        alpha_eff;
        logic                                 out_free;

        n_state     = r_state;
        n_d         = r_d;
        n_ds        = r_ds;
        n_div       = r_div;
        n_rem       = r_rem;
        n_pf        = r_pf;
        n_cnt       = r_cnt;
        n_epos      = r_epos;
        n_espd      = r_espd;
        n_ei        = r_ei;
        n_sum       = r_sum;
        n_x         = r_x;
        n_acc       = r_acc;
        n_tilt      = r_tilt;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        mul_req     = '0;

        mag       = r_d[bapid_pkg::DIFF_W-1] ? 17'(-r_d) : 17'(r_d);
        rem2      = {r_rem, bapid_pkg::PF_NUM_LO[r_cnt]};
        ge        = (rem2 >= {1'b0, r_div});
        integ_sum = 33'(r_ei) + 33'($signed(prod[26:4]));
        sum_full  = r_sum + 28'($signed(prod[33:10]));
        // x*256 is signed, so it is sign-extended before the subtract
        fdiff     = 19'($signed({r_x, 8'd0})) - 19'(r_acc);
        delta     = $signed(prod[27:8]);
        acc_sum   = 20'(r_acc) + delta;
        alpha_eff = (r_alpha > bapid_pkg::ALPHA_ONE) ? bapid_pkg::ALPHA_ONE : r_alpha;
        out_free  = !r_out_valid || i_m_axis_tready;

        case (r_state)
            // Take a word: form the 17-bit differences, clear filter on restart
            bapid_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_d  = 17'($signed(i_s_axis_tdata[15:0])) - 17'(r_tgt_pos);
                    n_ds = 17'($signed(i_s_axis_tdata[31:16])) - 17'(r_tgt_spd);
                    if (i_s_axis_tuser) begin
                        n_acc = '0;
                    end
                    n_state = bapid_pkg::S_PREP;
                end
            end
            // Divisor and divide seed
            bapid_pkg::S_PREP: begin
                n_div   = bapid_pkg::PF_BASE + mag;
                n_rem   = bapid_pkg::PF_SEED;
                n_pf    = '0;
                n_cnt   = 4'(bapid_pkg::PF_W - 1);
                n_state = bapid_pkg::S_DIV;
            end
            // One quotient bit per cycle, MSB first
            bapid_pkg::S_DIV: begin
                n_rem = ge ? 17'(rem2 - {1'b0, r_div}) : rem2[16:0];
                n_pf  = {r_pf[bapid_pkg::PF_W-2:0], ge};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = bapid_pkg::S_MUL_EPOS;
                end
            end
            bapid_pkg::S_MUL_EPOS: begin
                mul_req = '{en: 1'b1, a: 24'(r_d), b: 19'({1'b0, r_pf})};
                n_state = bapid_pkg::S_MUL_ESPD;
            end
            bapid_pkg::S_MUL_ESPD: begin
                n_epos  = prod[22:10];
                mul_req = '{en: 1'b1, a: 24'(r_ds), b: 19'({1'b0, r_pf})};
                n_state = bapid_pkg::S_MUL_INTEG;
            end
            bapid_pkg::S_MUL_INTEG: begin
                n_espd  = prod[27:10];
                mul_req = '{en: 1'b1, a: 24'(r_epos), b: 19'({1'b0, r_tick})};
                n_state = bapid_pkg::S_MUL_PROP;
            end
            // Saturating integral update
            bapid_pkg::S_MUL_PROP: begin
                if (integ_sum[32] != integ_sum[31]) begin
                    n_ei = integ_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                end else begin
                    n_ei = integ_sum[31:0];
                end
                mul_req = '{en: 1'b1, a: 24'(r_epos), b: 19'(r_prop_w)};
                n_state = bapid_pkg::S_MUL_ITERM;
            end
            bapid_pkg::S_MUL_ITERM: begin
                n_sum   = 28'($signed(prod[28:14]));
                mul_req = '{en: 1'b1, a: r_ei[31:8], b: 19'(r_integ_w)};
                n_state = bapid_pkg::S_MUL_DERIV;
            end
            bapid_pkg::S_MUL_DERIV: begin
                n_sum   = r_sum + 28'($signed(prod[39:14]));
                mul_req = '{en: 1'b1, a: 24'(r_espd), b: 19'(r_deriv_w)};
                n_state = bapid_pkg::S_CLAMP;
            end
            // Limit the PID sum to plus or minus 15 degrees
            bapid_pkg::S_CLAMP: begin
                if (sum_full > bapid_pkg::ANGLE_MAX) begin
                    n_x = bapid_pkg::ANGLE_MAX[8:0];
                end else if (sum_full < bapid_pkg::ANGLE_MIN) begin
                    n_x = bapid_pkg::ANGLE_MIN[8:0];
                end else begin
                    n_x = sum_full[8:0];
                end
                n_state = bapid_pkg::S_MUL_FILT;
            end
            bapid_pkg::S_MUL_FILT: begin
                mul_req = '{en: 1'b1, a: 24'(fdiff), b: 19'({1'b0, alpha_eff})};
                n_state = bapid_pkg::S_DONE;
            end
            // Filter update and hand-off to the output register
            bapid_pkg::S_DONE: begin
                if (out_free) begin
                    n_acc       = acc_sum[bapid_pkg::ACC_W-1:0];
                    n_tilt      = acc_sum[16:8];
                    n_out_valid = 1'b1;
                    n_state     = bapid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bapid_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/bapid_checker.sv]
// Port-level checks for the ball axis PID controller, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module bapid_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed under stall");

    // Tilt stays within plus or minus 15 degrees, upper bits zero
    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:9] == 7'd0) &&
            ($signed(o_m_axis_tdata[8:0]) <= 9'sd240) &&
            ($signed(o_m_axis_tdata[8:0]) >= -9'sd240))
        else $error("tilt out of range");

    // One word at a time: after acceptance the input is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after acceptance");

    // No result is shown right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind ball_axis_pid_controller bapid_checker u_bapid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
